// File: rtl/core/qpd_pkg.sv
// shared types, constants and helpers for the quoted-printable decoder
package qpd_pkg;

  localparam logic [7:0] EqChar  = 8'h3D;
  localparam logic [7:0] CrChar  = 8'h0D;
  localparam logic [7:0] LfChar  = 8'h0A;
  localparam logic [7:0] UpperA  = 8'h41;
  localparam logic [7:0] DigOffs = 8'h30;
  localparam logic [7:0] LetOffs = 8'h37;

  typedef enum logic [1:0] {
    QPD_PASS        = 2'd0,
    QPD_AFTER_EQ    = 2'd1,
    QPD_SECOND      = 2'd2,
    QPD_AFTER_BREAK = 2'd3
  } qpd_mode_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       is_last;
  } qpd_in_t;

  typedef struct packed {
    logic       has_byte;
    logic [7:0] out_byte;
    logic       end_of_text;
  } qpd_out_t;

  typedef struct packed {
    qpd_mode_e  mode;
    logic [3:0] high_nibble;
  } qpd_state_t;

  // signed-char style nibble: bytes at or above 0x80 take the digit offset
  function automatic logic [3:0] nibble_of(input logic [7:0] c);
    logic [7:0] v;
    if ((c < UpperA) || c[7]) begin
      v = c - DigOffs;
    end else begin
      v = c - LetOffs;
    end
    return v[3:0];
  endfunction

  function automatic logic is_break(input logic [7:0] c);
    return (c == CrChar) || (c == LfChar);
  endfunction

endpackage

// File: rtl/core/quoted_printable_decoder_unit.sv
// quoted-printable decoder top level: input register, decode, result register
//
// Input channel: in_valid_i / in_stall_o carry one text byte per request with
// an is_last flag on the final byte. Output channel: out_valid_o / out_stall_i
// carry exactly one result per input request: has_byte tells whether out_byte
// holds a decoded byte (it is zero otherwise), end_of_text copies is_last.
// Each accepted request passes through the input register and then the result
// register on its way to the output port. The decode state (mode and pending
// high nibble) updates as a byte moves from the input register into the
// result register, so one byte per cycle is sustained while out_stall_i is low.
// An "=" followed by cr or lf is a soft break and gives an empty result, as do
// the "=" and first hex character of an escape; an escape cut off by is_last
// gives nothing and the next byte starts a fresh text.
// Reset empties both registers and returns to pass-through mode. When the
// receiver stalls, the result is held; the input register still takes one
// more request, then in_stall_o rises until the result is taken.
module quoted_printable_decoder_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  qpd_pkg::qpd_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output qpd_pkg::qpd_out_t out_data_o
);

  logic                in_valid_q;
  qpd_pkg::qpd_in_t    in_q;
  logic                out_valid_q;
  qpd_pkg::qpd_out_t   out_q;
  qpd_pkg::qpd_state_t state_q, state_d;
  qpd_pkg::qpd_out_t   result;
  logic                out_free;
  logic                advance;
  logic                in_take;

  assign out_free = !out_valid_q || !out_stall_i;
  assign advance  = in_valid_q && out_free;
  assign in_take  = in_valid_i && !in_stall_o;
  assign in_stall_o = in_valid_q && !out_free;

  qpd_decode u_decode (
    .state_i  (state_q),
    .data_i   (in_q),
    .state_o  (state_d),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q          <= 1'b0;
      out_valid_q         <= 1'b0;
      state_q.mode        <= qpd_pkg::QPD_PASS;
      state_q.high_nibble <= 4'h0;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        state_q     <= state_d;
      end else if (out_free) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_data_i;
    end
    if (advance) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: rtl/core/qpd_decode.sv
// next-state and result logic for one text byte
module qpd_decode (
  input  qpd_pkg::qpd_state_t state_i,
  input  qpd_pkg::qpd_in_t    data_i,
  output qpd_pkg::qpd_state_t state_o,
  output qpd_pkg::qpd_out_t   result_o
);

  logic       brk;
  logic       eq;

  assign brk = qpd_pkg::is_break(data_i.in_byte);
  assign eq  = (data_i.in_byte == qpd_pkg::EqChar);

  always_comb begin
    state_o           = state_i;
    result_o.has_byte = 1'b0;
    result_o.out_byte = 8'h00;
    result_o.end_of_text = data_i.is_last;

    unique case (state_i.mode)
      qpd_pkg::QPD_AFTER_EQ: begin
        if (brk) begin
          state_o.mode = qpd_pkg::QPD_AFTER_BREAK;
        end else begin
          state_o.high_nibble = qpd_pkg::nibble_of(data_i.in_byte);
          state_o.mode        = qpd_pkg::QPD_SECOND;
        end
      end
      qpd_pkg::QPD_SECOND: begin
        result_o.has_byte = 1'b1;
        result_o.out_byte = {state_i.high_nibble, qpd_pkg::nibble_of(data_i.in_byte)};
        state_o.mode      = qpd_pkg::QPD_PASS;
      end
      qpd_pkg::QPD_AFTER_BREAK: begin
        // one more cr or lf after the soft break is swallowed
        if (brk) begin
          state_o.mode = qpd_pkg::QPD_PASS;
        end else if (eq) begin
          state_o.mode = qpd_pkg::QPD_AFTER_EQ;
        end else begin
          state_o.mode      = qpd_pkg::QPD_PASS;
          result_o.has_byte = 1'b1;
          result_o.out_byte = data_i.in_byte;
        end
      end
      default: begin
        if (eq) begin
          state_o.mode = qpd_pkg::QPD_AFTER_EQ;
        end else begin
          result_o.has_byte = 1'b1;
          result_o.out_byte = data_i.in_byte;
        end
      end
    endcase

    // end of text drops any unfinished escape
    if (data_i.is_last) begin
      state_o.mode        = qpd_pkg::QPD_PASS;
      state_o.high_nibble = 4'h0;
    end
  end

endmodule

// File: rtl/core/qpd_checker.sv
// port-level assertions for the quoted-printable decoder, bound to the top level
module qpd_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input qpd_pkg::qpd_in_t  in_data_i,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input qpd_pkg::qpd_out_t out_data_o
);

  // an empty result carries a zero byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.has_byte) |-> (out_data_o.out_byte == 8'h00))
    else $error("empty result with nonzero byte");

  // with no result waiting the input side never stalls
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled while output is empty");

  // a request accepted into an idle block shows up after the input and result registers
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && !out_valid_o && !$past(in_valid_i && !in_stall_o))
      |=> ##1 out_valid_o)
    else $error("result missing after request");

  // a stalled result stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled result changed");

  // a stalled request stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_stall_o) |=> (in_valid_i && $stable(in_data_i)))
    else $error("stalled request changed");

endmodule

bind quoted_printable_decoder_unit qpd_checker u_qpd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

// File: verif/tb_quoted_printable_decoder_unit.sv
// testbench for the quoted-printable decoder: random texts, stalls and a result scoreboard
`timescale 1ns / 100ps

module tb_quoted_printable_decoder_unit;

  localparam int CycleLimit = 400000;
  localparam int TailCycles = 10;
  localparam int HoldCycles = 300;
  localparam int PhaseItems = 450;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  qpd_pkg::qpd_in_t  in_data_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  qpd_pkg::qpd_out_t out_data_o;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_left = 0;
  int items_sent = 0;
  int cycle_count = 0;

  quoted_printable_decoder_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  class qp_decode_scoreboard;
    qpd_pkg::qpd_mode_e  mode;
    logic [3:0]          high_nib;
    qpd_pkg::qpd_out_t   decoded_q[$];
    int                  errors;
    int                  results_seen;

    function new();
      mode = qpd_pkg::QPD_PASS;
      high_nib = '0;
      errors = 0;
      results_seen = 0;
    endfunction

    // bytes at or above 0x80 count as negative chars and take the digit offset
    function logic [3:0] char_nibble(logic [7:0] c);
      logic [7:0] v;
      if (c < qpd_pkg::UpperA || c >= 8'h80) begin
        v = c - qpd_pkg::DigOffs;
      end else begin
        v = c - qpd_pkg::LetOffs;
      end
      return v[3:0];
    endfunction

    function void note_request(qpd_pkg::qpd_in_t req);
      qpd_pkg::qpd_out_t e;
      logic [7:0]        b;
      logic              brk;
      b = req.in_byte;
      brk = (b == qpd_pkg::CrChar) || (b == qpd_pkg::LfChar);
      e = '0;
      e.end_of_text = req.is_last;
      case (mode)
        qpd_pkg::QPD_AFTER_EQ: begin
          if (brk) begin
            mode = qpd_pkg::QPD_AFTER_BREAK;
          end else begin
            high_nib = char_nibble(b);
            mode = qpd_pkg::QPD_SECOND;
          end
        end
        qpd_pkg::QPD_SECOND: begin
          e.has_byte = 1'b1;
          e.out_byte = {high_nib, char_nibble(b)};
          mode = qpd_pkg::QPD_PASS;
        end
        default: begin
          // one more cr or lf after a soft break is swallowed
          if (mode == qpd_pkg::QPD_AFTER_BREAK && brk) begin
            mode = qpd_pkg::QPD_PASS;
          end else if (b == qpd_pkg::EqChar) begin
            mode = qpd_pkg::QPD_AFTER_EQ;
          end else begin
            e.has_byte = 1'b1;
            e.out_byte = b;
            mode = qpd_pkg::QPD_PASS;
          end
        end
      endcase
      if (req.is_last) begin
        mode = qpd_pkg::QPD_PASS;
        high_nib = '0;
      end
      decoded_q.push_back(e);
    endfunction

    task report(string msg);
      if (errors < 100) begin
        $display("mismatch: %s", msg);
      end
      errors++;
    endtask

    task check_result(qpd_pkg::qpd_out_t got);
      qpd_pkg::qpd_out_t exp;
      results_seen++;
      if (decoded_q.size() == 0) begin
        report($sformatf("result %0d arrived with no request pending", results_seen));
      end else begin
        exp = decoded_q.pop_front();
        if (got.has_byte !== exp.has_byte) begin
          report($sformatf("result %0d has_byte %b, expected %b", results_seen,
                           got.has_byte, exp.has_byte));
        end
        if (got.out_byte !== exp.out_byte) begin
          report($sformatf("result %0d out_byte %h, expected %h", results_seen,
                           got.out_byte, exp.out_byte));
        end
        if (got.end_of_text !== exp.end_of_text) begin
          report($sformatf("result %0d end_of_text %b, expected %b", results_seen,
                           got.end_of_text, exp.end_of_text));
        end
      end
    endtask

    function int pending();
      return decoded_q.size();
    endfunction
  endclass

  qp_decode_scoreboard sb;

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("tb_quoted_printable_decoder_unit NOT OK");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_result(out_data_o);
    end
  end

  // receiver: random stalls, or a long hold-off counted down here
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    qpd_pkg::qpd_in_t req;
    req.in_byte = b;
    req.is_last = last;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= req;
    @(posedge clk_i);
    while (in_stall_o) begin
      @(posedge clk_i);
    end
    sb.note_request(req);
    items_sent++;
  endtask

  function automatic logic [7:0] hex_char(int idx);
    if (idx < 10) begin
      return 8'(8'h30 + idx);
    end else if (idx < 16) begin
      return 8'(8'h41 + idx - 10);
    end
    return 8'(8'h61 + idx - 16);
  endfunction

  function automatic logic [7:0] break_char();
    return $urandom_range(1) ? qpd_pkg::CrChar : qpd_pkg::LfChar;
  endfunction

  // mostly well-formed text: plain chars, escapes, soft breaks, some noise
  task automatic send_text(input int n_tokens);
    logic [7:0] txt[$];
    int         pick;
    for (int t = 0; t < n_tokens; t++) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        txt.push_back(8'($urandom_range(8'h20, 8'h7E)));
      end else if (pick < 68) begin
        txt.push_back(qpd_pkg::EqChar);
        txt.push_back(hex_char($urandom_range(21)));
        txt.push_back(hex_char($urandom_range(21)));
      end else if (pick < 80) begin
        txt.push_back(qpd_pkg::EqChar);
        txt.push_back(break_char());
        if ($urandom_range(1)) begin
          txt.push_back(break_char());
        end
      end else if (pick < 85) begin
        txt.push_back(break_char());
      end else begin
        txt.push_back(8'($urandom_range(255)));
      end
    end
    // escape cut off by the end of text
    pick = $urandom_range(99);
    if (pick < 8) begin
      txt.push_back(qpd_pkg::EqChar);
    end else if (pick < 16) begin
      txt.push_back(qpd_pkg::EqChar);
      txt.push_back(8'($urandom_range(255)));
    end
    for (int i = 0; i < txt.size(); i++) begin
      send_byte(txt[i], i == txt.size() - 1);
    end
  endtask

  initial begin
    sb = new();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(qpd_pkg::EqChar, 1'b0);
    send_byte(8'h34, 1'b0);
    send_byte(8'h31, 1'b0);
    send_byte(qpd_pkg::EqChar, 1'b0);
    send_byte(8'h66, 1'b0);
    send_byte(8'h61, 1'b0);
    send_byte(qpd_pkg::EqChar, 1'b0);
    send_byte(8'hC1, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(qpd_pkg::EqChar, 1'b0);
    send_byte(qpd_pkg::CrChar, 1'b0);
    send_byte(qpd_pkg::LfChar, 1'b0);
    send_byte(qpd_pkg::LfChar, 1'b0);
    // soft break followed directly by a new escape
    send_byte(qpd_pkg::EqChar, 1'b0);
    send_byte(qpd_pkg::LfChar, 1'b0);
    send_byte(qpd_pkg::EqChar, 1'b0);
    send_byte(qpd_pkg::EqChar, 1'b0);
    send_byte(8'h7A, 1'b0);
    send_byte(qpd_pkg::EqChar, 1'b0);
    send_byte(qpd_pkg::CrChar, 1'b0);
    send_byte(8'h78, 1'b0);
    send_byte(qpd_pkg::EqChar, 1'b1);
    send_byte(qpd_pkg::EqChar, 1'b0);
    send_byte(8'h41, 1'b1);
    send_byte(8'h7F, 1'b1);
    send_byte(qpd_pkg::EqChar, 1'b0);
    send_byte(qpd_pkg::CrChar, 1'b1);

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
          hold_left = HoldCycles;
        end
        1: begin
          send_idle_pct = 76;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 76;
        end
        default: begin
          send_idle_pct = 27;
          recv_stall_pct = 27;
        end
      endcase
      while (items_sent < 30 + PhaseItems * (p + 1)) begin
        send_text($urandom_range(1, 12));
      end
    end
    in_valid_i <= 1'b0;

    while (sb.pending() != 0) begin
      @(posedge clk_i);
    end
    repeat (TailCycles) @(posedge clk_i);
    if (sb.pending() != 0) begin
      sb.report("requests left without a result");
    end
    if (sb.errors == 0) begin
      $display("tb_quoted_printable_decoder_unit OK");
    end else begin
      $display("tb_quoted_printable_decoder_unit NOT OK");
    end
    $finish;
  end

endmodule
